/* rtl/tsp_pkg.sv */
package tsp_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W = 48;
    localparam int HANDLE_W = 32;
    localparam int WINDOW_W = 32;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(100000);

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_PAIR    = 2'd1,
        ST_REFUSED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_DEC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0]   stamp;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic push;
        logic set_none;
        logic set_refused;
        logic calc_gap;
        logic drop;
        logic pair;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic target_full;
        logic both_nonempty;
        logic gap_over;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/tsp_in_if.sv */
interface tsp_in_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [tsp_pkg::TIME_W-1:0]     timestamp;
    logic [tsp_pkg::HANDLE_W-1:0]   handle;

    modport source (output valid, command, timestamp, handle, input ready);
    modport sink (input valid, command, timestamp, handle, output ready);
endinterface

/* rtl/tsp_out_if.sv */
interface tsp_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [tsp_pkg::HANDLE_W-1:0]   image_handle;
    logic [tsp_pkg::HANDLE_W-1:0]   depth_handle;
    logic [tsp_pkg::TIME_W-1:0]     image_time;
    logic [tsp_pkg::TIME_W-1:0]     depth_time;

    modport source (output valid, status, image_handle, depth_handle, image_time,
                    depth_time, input ready);
    modport sink (input valid, status, image_handle, depth_handle, image_time,
                  depth_time, output ready);
endinterface

/* rtl/tsp_ctrl.sv */
module tsp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tsp_pkg::t_dp_sts i_sts,
    output tsp_pkg::t_dp_cmd o_cmd
);

    tsp_pkg::t_state r_state;
    tsp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            tsp_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_sts.target_full) begin
                        o_cmd.set_refused = 1'b1;
                        n_state = tsp_pkg::S_EMIT;
                    end else begin
                        o_cmd.push = 1'b1;
                        n_state = tsp_pkg::S_READ;
                    end
                end
            end
            tsp_pkg::S_READ: begin
                if (i_sts.both_nonempty) begin
                    n_state = tsp_pkg::S_DIFF;
                end else begin
                    o_cmd.set_none = 1'b1;
                    n_state = tsp_pkg::S_EMIT;
                end
            end
            tsp_pkg::S_DIFF: begin
                o_cmd.calc_gap = 1'b1;
                n_state = tsp_pkg::S_DEC;
            end
            tsp_pkg::S_DEC: begin
                if (i_sts.gap_over) begin
                    o_cmd.drop = 1'b1;
                    n_state = tsp_pkg::S_READ;
                end else begin
                    o_cmd.pair = 1'b1;
                    n_state = tsp_pkg::S_EMIT;
                end
            end
            tsp_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = tsp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tsp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/tsp_datapath.sv */
module tsp_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [tsp_pkg::WINDOW_W-1:0]   i_cfg_wr_data,
    input  logic                           i_command,
    input  logic [tsp_pkg::TIME_W-1:0]     i_timestamp,
    input  logic [tsp_pkg::HANDLE_W-1:0]   i_handle,
    input  tsp_pkg::t_dp_cmd               i_cmd,
    output tsp_pkg::t_dp_sts               o_sts,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [1:0]                     o_status,
    output logic [tsp_pkg::HANDLE_W-1:0]   o_image_handle,
    output logic [tsp_pkg::HANDLE_W-1:0]   o_depth_handle,
    output logic [tsp_pkg::TIME_W-1:0]     o_image_time,
    output logic [tsp_pkg::TIME_W-1:0]     o_depth_time
);

    localparam logic [tsp_pkg::IDX_W:0] DEPTH_X = (tsp_pkg::IDX_W + 1)'(tsp_pkg::QUEUE_DEPTH);
    localparam logic [tsp_pkg::IDX_W-1:0] LAST_IDX =
        tsp_pkg::IDX_W'(tsp_pkg::QUEUE_DEPTH - 1);
    localparam logic [tsp_pkg::CNT_W-1:0] FULL_CNT =
        tsp_pkg::CNT_W'(tsp_pkg::QUEUE_DEPTH);

    tsp_pkg::t_entry r_img_mem [tsp_pkg::QUEUE_DEPTH];
    tsp_pkg::t_entry r_dep_mem [tsp_pkg::QUEUE_DEPTH];
    tsp_pkg::t_entry r_img_rd;
    tsp_pkg::t_entry r_dep_rd;

    logic [tsp_pkg::IDX_W-1:0] r_img_head;
    logic [tsp_pkg::IDX_W-1:0] r_dep_head;
    logic [tsp_pkg::CNT_W-1:0] r_img_cnt;
    logic [tsp_pkg::CNT_W-1:0] r_dep_cnt;
    logic [tsp_pkg::IDX_W-1:0] n_img_head;
    logic [tsp_pkg::IDX_W-1:0] n_dep_head;
    logic [tsp_pkg::IDX_W:0]   img_sum;
    logic [tsp_pkg::IDX_W:0]   dep_sum;
    logic [tsp_pkg::IDX_W-1:0] img_tail;
    logic [tsp_pkg::IDX_W-1:0] dep_tail;

    logic [tsp_pkg::WINDOW_W-1:0] r_window;
    logic [tsp_pkg::TIME_W-1:0]   r_gap;
    logic                         r_img_older;
    logic                         pop_img;
    logic                         pop_dep;
    logic                         push_img;
    logic                         push_dep;

    tsp_pkg::t_status             r_pend_status;
    tsp_pkg::t_entry              r_pend_img;
    tsp_pkg::t_entry              r_pend_dep;
    tsp_pkg::t_status             r_out_status;
    tsp_pkg::t_entry              r_out_img;
    tsp_pkg::t_entry              r_out_dep;
    logic                         r_out_valid;

    always_comb begin
        n_img_head = (r_img_head == LAST_IDX) ? '0 : r_img_head + 1'b1;
        n_dep_head = (r_dep_head == LAST_IDX) ? '0 : r_dep_head + 1'b1;
        img_sum    = (tsp_pkg::IDX_W + 1)'(r_img_head) + (tsp_pkg::IDX_W + 1)'(r_img_cnt);
        dep_sum    = (tsp_pkg::IDX_W + 1)'(r_dep_head) + (tsp_pkg::IDX_W + 1)'(r_dep_cnt);
        img_tail   = (img_sum >= DEPTH_X) ? tsp_pkg::IDX_W'(img_sum - DEPTH_X)
                                          : tsp_pkg::IDX_W'(img_sum);
        dep_tail   = (dep_sum >= DEPTH_X) ? tsp_pkg::IDX_W'(dep_sum - DEPTH_X)
                                          : tsp_pkg::IDX_W'(dep_sum);
        push_img   = i_cmd.push && !i_command;
        push_dep   = i_cmd.push && i_command;
        pop_img    = i_cmd.pair || (i_cmd.drop && r_img_older);
        pop_dep    = i_cmd.pair || (i_cmd.drop && !r_img_older);
    end

    always_ff @(posedge i_clk) begin
        if (push_img) begin
            r_img_mem[img_tail] <= '{stamp: i_timestamp, handle: i_handle};
        end
        if (push_dep) begin
            r_dep_mem[dep_tail] <= '{stamp: i_timestamp, handle: i_handle};
        end
        r_img_rd <= r_img_mem[r_img_head];
        r_dep_rd <= r_dep_mem[r_dep_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_head <= '0;
            r_dep_head <= '0;
            r_img_cnt  <= '0;
            r_dep_cnt  <= '0;
        end else begin
            if (push_img) begin
                r_img_cnt <= r_img_cnt + 1'b1;
            end else if (pop_img) begin
                r_img_cnt  <= r_img_cnt - 1'b1;
                r_img_head <= n_img_head;
            end
            if (push_dep) begin
                r_dep_cnt <= r_dep_cnt + 1'b1;
            end else if (pop_dep) begin
                r_dep_cnt  <= r_dep_cnt - 1'b1;
                r_dep_head <= n_dep_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= tsp_pkg::WINDOW_RESET;
        end else if (i_cfg_wr_en) begin
            r_window <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_gap) begin
            r_img_older <= (r_img_rd.stamp <= r_dep_rd.stamp);
            r_gap <= (r_img_rd.stamp > r_dep_rd.stamp) ? r_img_rd.stamp - r_dep_rd.stamp
                                                       : r_dep_rd.stamp - r_img_rd.stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pair) begin
            r_pend_status <= tsp_pkg::ST_PAIR;
            r_pend_img    <= r_img_rd;
            r_pend_dep    <= r_dep_rd;
        end else if (i_cmd.set_none || i_cmd.set_refused) begin
            r_pend_status <= i_cmd.set_refused ? tsp_pkg::ST_REFUSED : tsp_pkg::ST_NONE;
            r_pend_img    <= '0;
            r_pend_dep    <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= r_pend_status;
            r_out_img    <= r_pend_img;
            r_out_dep    <= r_pend_dep;
        end
    end

    always_comb begin
        o_sts.target_full   = i_command ? (r_dep_cnt == FULL_CNT) : (r_img_cnt == FULL_CNT);
        o_sts.both_nonempty = (r_img_cnt != '0) && (r_dep_cnt != '0);
        o_sts.gap_over      = r_gap > tsp_pkg::TIME_W'(r_window);
        o_sts.out_free      = !r_out_valid || i_ready;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_image_handle = r_out_img.handle;
    assign o_depth_handle = r_out_dep.handle;
    assign o_image_time   = r_out_img.stamp;
    assign o_depth_time   = r_out_dep.stamp;

endmodule

/* rtl/two_stream_timestamp_pairer.sv */
// Pairs color and depth frames whose capture times lie within a window.
// Requests enter on i_arrival: command selects the color (0) or depth (1)
// stream, with the frame's timestamp and buffer handle. Each stream has its
// own FIFO of 16 entries. Every accepted request yields exactly one result on
// o_result: status none, pair (with both handles and times), or refused when
// the selected FIFO was already full. The window is written through
// i_cfg_wr_en and i_cfg_wr_data. The user must write it only while the block
// is idle; the block itself does not enforce this. One request is handled at
// a time. A refused request passes through the pending result register into
// the output register. Each head compare runs through the READ, DIFF and DEC
// states, and at most 16 + 15 heads are dropped per request. A result without
// a pair is given once either FIFO is empty. The next request is taken the
// cycle after the result is loaded into the output register. Reset clears both
// FIFOs, sets the window to 100000 and empties the output register. A stalled
// receiver holds the result in the output register; the block still takes one
// more request and parks its result.
module two_stream_timestamp_pairer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [tsp_pkg::WINDOW_W-1:0]   i_cfg_wr_data,
    tsp_in_if.sink                         i_arrival,
    tsp_out_if.source                      o_result
);

    tsp_pkg::t_dp_cmd cmd;
    tsp_pkg::t_dp_sts sts;

    tsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_arrival.valid),
        .o_in_ready (i_arrival.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tsp_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_command      (i_arrival.command),
        .i_timestamp    (i_arrival.timestamp),
        .i_handle       (i_arrival.handle),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_result.valid),
        .i_ready        (o_result.ready),
        .o_status       (o_result.status),
        .o_image_handle (o_result.image_handle),
        .o_depth_handle (o_result.depth_handle),
        .o_image_time   (o_result.image_time),
        .o_depth_time   (o_result.depth_time)
    );

endmodule
